[rtl/emergency_lighting_mode_controller_defines.svh]
// Assertion helpers for the checker file.
`ifndef EMERGENCY_LIGHTING_MODE_CONTROLLER_DEFINES_SVH
`define EMERGENCY_LIGHTING_MODE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define ELMC_ASSERT_NOW(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("elmc assertion failed");

// Next-cycle implication, disabled while in reset.
`define ELMC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("elmc assertion failed");

`endif

[rtl/elmc_pkg.sv]
package elmc_pkg;

	// request codes
	localparam logic [2:0] REQ_TICK      = 3'd0;
	localparam logic [2:0] REQ_REST      = 3'd1;
	localparam logic [2:0] REQ_INHIBIT   = 3'd2;
	localparam logic [2:0] REQ_RELIGHT   = 3'd3;
	localparam logic [2:0] REQ_FUNC_TEST = 3'd4;
	localparam logic [2:0] REQ_DUR_TEST  = 3'd5;
	localparam logic [2:0] REQ_STOP_TEST = 3'd6;
	localparam logic [2:0] REQ_LAMP_CLR  = 3'd7;

	// default test / inhibit lengths in ticks
	localparam logic [11:0] DUR_TEST_TICKS_DEF  = 12'd3600;
	localparam logic [9:0]  INHIBIT_TICKS_DEF   = 10'd900;
	localparam logic [2:0]  FUNC_TEST_TICKS_DEF = 3'd5;

	localparam int unsigned PROLONG_STEP = 30;
	localparam int unsigned EMG_STEP     = 60 * 60;
	localparam int unsigned TOT_STEP     = 60 * 60 * 4;
	localparam logic [11:0] EMG_LAST     = 12'(EMG_STEP - 1);
	localparam logic [13:0] TOT_LAST     = 14'(TOT_STEP - 1);
	localparam logic [6:0]  FULL_PERCENT = 7'd100;

	// x / 120 = (x >> 3) / 15, and /15 as * 4370 >> 16 (exact for x < 4096)
	localparam logic [12:0] DUR_RECIP = 13'd4370;
	// p * 254 / 100 as p * 166462 >> 16 (exact for p <= 100)
	localparam logic [17:0] CHARGE_RECIP = 18'd166462;

	typedef struct packed {
		logic emg_inc;
		logic tot_inc;
		logic clear;
	} lamp_ctl_t;

endpackage

[rtl/elmc_req_if.sv]
interface elmc_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] req_type;
	logic       mains_on;
	logic       shorten_test;
	logic [6:0] battery_percent;

	modport source (output valid, req_type, mains_on, shorten_test, battery_percent,
		input ready);
	modport sink (input valid, req_type, mains_on, shorten_test, battery_percent,
		output ready);
endinterface

[rtl/elmc_rsp_if.sv]
interface elmc_rsp_if;
	logic       valid;
	logic       ready;
	logic [5:0] mode_bits;
	logic [5:0] status_bits;
	logic [7:0] failure_bits;
	logic [7:0] battery_charge;
	logic [7:0] duration_result;
	logic [7:0] lamp_emergency_hours;
	logic [7:0] lamp_total_units;

	modport source (output valid, mode_bits, status_bits, failure_bits, battery_charge,
		duration_result, lamp_emergency_hours, lamp_total_units, input ready);
	modport sink (input valid, mode_bits, status_bits, failure_bits, battery_charge,
		duration_result, lamp_emergency_hours, lamp_total_units, output ready);
endinterface

[rtl/elmc_lamp_timer.sv]
// Lamp time counters kept as quotient/remainder pairs, so the coarse
// units need no divider. Quotients stick at 255.
module elmc_lamp_timer
	import elmc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  lamp_ctl_t ctl,
	output logic [7:0] emg_hours,
	output logic [7:0] tot_units
);

	logic [11:0] emg_rem_q, emg_rem_n;
	logic [7:0]  emg_hr_q, emg_hr_n;
	logic [13:0] tot_rem_q, tot_rem_n;
	logic [7:0]  tot_un_q, tot_un_n;

	always_comb begin
		emg_rem_n = emg_rem_q;
		emg_hr_n  = emg_hr_q;
		tot_rem_n = tot_rem_q;
		tot_un_n  = tot_un_q;
		if (ctl.clear) begin
			emg_rem_n = '0;
			emg_hr_n  = '0;
			tot_rem_n = '0;
			tot_un_n  = '0;
		end
		if (ctl.emg_inc && emg_hr_q != 8'hFF) begin
			if (emg_rem_q == EMG_LAST) begin
				emg_rem_n = '0;
				emg_hr_n  = emg_hr_q + 8'd1;
			end else begin
				emg_rem_n = emg_rem_q + 12'd1;
			end
		end
		if (ctl.tot_inc && tot_un_q != 8'hFF) begin
			if (tot_rem_q == TOT_LAST) begin
				tot_rem_n = '0;
				tot_un_n  = tot_un_q + 8'd1;
			end else begin
				tot_rem_n = tot_rem_q + 14'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emg_rem_q <= '0;
			emg_hr_q  <= '0;
			tot_rem_q <= '0;
			tot_un_q  <= '0;
		end else if (step) begin
			emg_rem_q <= emg_rem_n;
			emg_hr_q  <= emg_hr_n;
			tot_rem_q <= tot_rem_n;
			tot_un_q  <= tot_un_n;
		end
	end

	assign emg_hours = emg_hr_n;
	assign tot_units = tot_un_n;

endmodule

[rtl/elmc_mode_core.sv]
// Mode machine, status flags and test counters. Results reflect the
// state after the item.
module elmc_mode_core
	import elmc_pkg::*;
#(
	parameter logic [11:0] DURATION_TEST_TICKS = DUR_TEST_TICKS_DEF,
	parameter logic [9:0]  INHIBIT_TICKS       = INHIBIT_TICKS_DEF,
	parameter logic [2:0]  FUNCTION_TEST_TICKS = FUNC_TEST_TICKS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] prolong_time,
	input  logic [2:0] req_type,
	input  logic       mains_on,
	input  logic       shorten_test,
	input  logic [6:0] battery_percent,
	output lamp_ctl_t  lamp_ctl,
	output logic [5:0] mode_bits,
	output logic [5:0] status_bits,
	output logic [7:0] failure_bits,
	output logic [7:0] battery_charge,
	output logic [7:0] duration_result
);

	typedef enum logic [2:0] {
		M_NORMAL, M_INHIBIT, M_REST, M_EMERG, M_EXT, M_FUNC, M_DUR
	} mode_t;

	mode_t       mode_q, mode_n, tgt;
	logic        enter;
	logic        inh_q, inh_n;
	logic        fdone_q, fdone_n, ddone_q, ddone_n, chg_q, chg_n;
	logic        fpend_q, fpend_n, dpend_q, dpend_n;
	logic        bfail_q, bfail_n;
	logic [9:0]  icnt_q, icnt_n;
	logic [12:0] pcnt_q, pcnt_n;
	logic [2:0]  fcnt_q, fcnt_n, fcnt_inc;
	logic [11:0] dcnt_q, dcnt_n, dcnt_inc;
	logic [12:0] plim;
	logic [6:0]  batt;
	logic        full, empty;
	logic [21:0] dprod;
	logic [24:0] cprod;

	assign batt  = (battery_percent > FULL_PERCENT) ? FULL_PERCENT : battery_percent;
	assign full  = (batt == FULL_PERCENT);
	assign empty = (batt == 7'd0);
	assign plim  = 13'(prolong_time) * 13'(PROLONG_STEP);
	assign fcnt_inc = (fcnt_q != 3'd7) ? fcnt_q + 3'd1 : fcnt_q;
	assign dcnt_inc = (dcnt_q != 12'hFFF) ? dcnt_q + 12'd1 : dcnt_q;

	always_comb begin
		mode_n  = mode_q;
		tgt     = mode_q;
		enter   = 1'b0;
		inh_n   = inh_q;
		fdone_n = fdone_q;
		ddone_n = ddone_q;
		chg_n   = chg_q;
		fpend_n = fpend_q;
		dpend_n = dpend_q;
		bfail_n = bfail_q;
		icnt_n  = icnt_q;
		pcnt_n  = pcnt_q;
		fcnt_n  = fcnt_q;
		dcnt_n  = dcnt_q;
		lamp_ctl = '0;

		case (req_type)
			REQ_TICK: begin
				case (mode_q)
					M_FUNC: begin
						if (!mains_on) begin
							enter = 1'b1; tgt = M_EMERG;
						end else begin
							fcnt_n = fcnt_inc;
							if (fcnt_inc == FUNCTION_TEST_TICKS) begin
								fdone_n = 1'b1;
								enter = 1'b1; tgt = M_NORMAL;
							end
						end
					end
					M_DUR: begin
						if (!mains_on) begin
							enter = 1'b1; tgt = M_EMERG;
						end else begin
							dcnt_n = dcnt_inc;
							if (dcnt_inc == DURATION_TEST_TICKS || shorten_test || empty) begin
								ddone_n = 1'b1;
								enter = 1'b1; tgt = M_NORMAL;
							end
							if (shorten_test) begin
								dcnt_n = DURATION_TEST_TICKS;
							end
							if (empty) begin
								bfail_n = 1'b1;
							end
						end
					end
					M_NORMAL: begin
						if (!mains_on) begin
							enter = 1'b1; tgt = M_EMERG;
						end else if (fpend_q && full) begin
							enter = 1'b1; tgt = M_FUNC;
						end else if (dpend_q && full) begin
							enter = 1'b1; tgt = M_DUR;
						end
					end
					M_INHIBIT: begin
						if (!mains_on) begin
							enter = 1'b1; tgt = M_REST;
						end else if (icnt_q >= INHIBIT_TICKS) begin
							enter = 1'b1; tgt = M_NORMAL;
						end else if (icnt_q != 10'h3FF) begin
							icnt_n = icnt_q + 10'd1;
						end
					end
					M_REST: begin
						if (mains_on) begin
							enter = 1'b1; tgt = M_NORMAL;
						end
					end
					M_EMERG: begin
						if (mains_on) begin
							enter  = 1'b1;
							tgt    = (prolong_time != 8'd0) ? M_EXT : M_NORMAL;
							pcnt_n = '0;
						end else if (empty) begin
							enter = 1'b1; tgt = M_REST;
						end else begin
							lamp_ctl.emg_inc = 1'b1;
						end
					end
					M_EXT: begin
						if (!mains_on) begin
							enter = 1'b1; tgt = M_EMERG;
						end else if (pcnt_q >= plim || empty) begin
							enter = 1'b1; tgt = M_NORMAL;
						end else if (pcnt_q != 13'h1FFF) begin
							pcnt_n = pcnt_q + 13'd1;
						end
					end
					default: begin
						enter = 1'b1; tgt = M_NORMAL;
					end
				endcase
				chg_n = full;
				lamp_ctl.tot_inc = 1'b1;
			end
			REQ_REST: begin
				if (mode_q == M_EMERG) begin
					enter = 1'b1; tgt = M_REST;
				end
			end
			REQ_INHIBIT: begin
				if (mode_q == M_NORMAL) begin
					enter = 1'b1; tgt = M_INHIBIT;
					icnt_n = '0;
				end else if (mode_q == M_INHIBIT) begin
					icnt_n = '0;
				end
			end
			REQ_RELIGHT: begin
				if (mode_q == M_REST) begin
					enter = 1'b1; tgt = M_EMERG;
				end else if (mode_q == M_INHIBIT) begin
					enter = 1'b1; tgt = M_NORMAL;
				end
			end
			REQ_FUNC_TEST: begin
				if (mode_q == M_NORMAL) begin
					enter = 1'b1; tgt = M_FUNC;
				end else begin
					fpend_n = 1'b1;
				end
			end
			REQ_DUR_TEST: begin
				if (mode_q == M_NORMAL && full) begin
					enter = 1'b1; tgt = M_DUR;
				end else begin
					dpend_n = 1'b1;
				end
			end
			REQ_STOP_TEST: begin
				if (mode_q == M_DUR || mode_q == M_FUNC) begin
					enter = 1'b1; tgt = M_NORMAL;
				end
				fpend_n = 1'b0;
				dpend_n = 1'b0;
			end
			default: begin
				lamp_ctl.clear = 1'b1;
			end
		endcase

		// side effects of a mode entry
		if (enter) begin
			mode_n = tgt;
			if (tgt == M_INHIBIT) begin
				inh_n = 1'b1;
			end else if (tgt != M_REST) begin
				inh_n = 1'b0;
			end
			if (tgt == M_FUNC) begin
				fdone_n = 1'b0;
				fpend_n = 1'b0;
				fcnt_n  = '0;
			end else if (tgt == M_DUR) begin
				ddone_n = 1'b0;
				dpend_n = 1'b0;
				dcnt_n  = '0;
			end
		end

		// step is applied to the lamp counters only when the item moves
		lamp_ctl.emg_inc = lamp_ctl.emg_inc & step;
		lamp_ctl.tot_inc = lamp_ctl.tot_inc & step;
		lamp_ctl.clear   = lamp_ctl.clear & step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_NORMAL;
			inh_q   <= 1'b0;
			fdone_q <= 1'b0;
			ddone_q <= 1'b0;
			chg_q   <= 1'b0;
			fpend_q <= 1'b0;
			dpend_q <= 1'b0;
			bfail_q <= 1'b0;
			icnt_q  <= '0;
			pcnt_q  <= '0;
			fcnt_q  <= '0;
			dcnt_q  <= '0;
		end else if (step) begin
			mode_q  <= mode_n;
			inh_q   <= inh_n;
			fdone_q <= fdone_n;
			ddone_q <= ddone_n;
			chg_q   <= chg_n;
			fpend_q <= fpend_n;
			dpend_q <= dpend_n;
			bfail_q <= bfail_n;
			icnt_q  <= icnt_n;
			pcnt_q  <= pcnt_n;
			fcnt_q  <= fcnt_n;
			dcnt_q  <= dcnt_n;
		end
	end

	always_comb begin
		case (mode_n)
			M_REST:               mode_bits = 6'b000001;
			M_NORMAL, M_INHIBIT:  mode_bits = 6'b000010;
			M_EMERG:              mode_bits = 6'b000100;
			M_EXT:                mode_bits = 6'b001000;
			M_FUNC:               mode_bits = 6'b010000;
			default:              mode_bits = 6'b100000;
		endcase
	end

	assign status_bits  = {dpend_n, fpend_n, chg_n, ddone_n, fdone_n, inh_n};
	assign failure_bits = {5'b0, bfail_n, 2'b0};

	assign dprod           = 22'(dcnt_n[11:3]) * 22'(DUR_RECIP);
	assign duration_result = {2'b0, dprod[21:16]};
	assign cprod           = 25'(batt) * 25'(CHARGE_RECIP);
	assign battery_charge  = cprod[23:16];

endmodule

[rtl/emergency_lighting_mode_controller.sv]
// Accepted requests go to the input stage, then to the result register driving rsp.
// Throughput: one request per cycle unless rsp stalls; the mode logic sits
// between the input stage and the result register, and state is updated as the
// request moves to the result. Reset (arst_n low, asynchronous): normal mode,
// all flags, counters and lamp times cleared, prolong_time zero, both stages empty.
module emergency_lighting_mode_controller
	import elmc_pkg::*;
#(
	parameter logic [11:0] DURATION_TEST_TICKS = DUR_TEST_TICKS_DEF,
	parameter logic [9:0]  INHIBIT_TICKS       = INHIBIT_TICKS_DEF,
	parameter logic [2:0]  FUNCTION_TEST_TICKS = FUNC_TEST_TICKS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	elmc_req_if.sink   req,
	elmc_rsp_if.source rsp,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data
);

	// extended emergency length in 30 s steps
	logic [7:0] prolong_q;

	// input stage: holds one accepted request
	logic       v_s1;
	logic [2:0] req_type_s1;
	logic       mains_on_s1;
	logic       shorten_s1;
	logic [6:0] batt_s1;

	// result register
	logic       out_v_q;
	logic [5:0] mode_q, status_q;
	logic [7:0] fail_q, charge_q, dur_q, emg_q, tot_q;

	// core results for the request in the input stage
	logic [5:0] mode_c, status_c;
	logic [7:0] fail_c, charge_c, dur_c, emg_c, tot_c;
	lamp_ctl_t  lamp_ctl;

	logic out_free;  // result register can be loaded this cycle
	logic step;      // request in s1 moves to the result register

	assign out_free  = !out_v_q || rsp.ready;
	assign step      = v_s1 && out_free;
	// s1 can take a new request when empty or when it drains this cycle
	assign req.ready = !v_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prolong_q <= '0;
		end else if (cfg_wr_en) begin
			prolong_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid;
		end
	end

	// payload: no reset needed
	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_type_s1 <= req.req_type;
			mains_on_s1 <= req.mains_on;
			shorten_s1  <= req.shorten_test;
			batt_s1     <= req.battery_percent;
		end
	end

	elmc_mode_core #(
		.DURATION_TEST_TICKS(DURATION_TEST_TICKS),
		.INHIBIT_TICKS(INHIBIT_TICKS),
		.FUNCTION_TEST_TICKS(FUNCTION_TEST_TICKS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.prolong_time(prolong_q),
		.req_type(req_type_s1),
		.mains_on(mains_on_s1),
		.shorten_test(shorten_s1),
		.battery_percent(batt_s1),
		.lamp_ctl(lamp_ctl),
		.mode_bits(mode_c),
		.status_bits(status_c),
		.failure_bits(fail_c),
		.battery_charge(charge_c),
		.duration_result(dur_c)
	);

	// lamp times kept as coarse units plus remainder
	elmc_lamp_timer u_lamp (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.ctl(lamp_ctl),
		.emg_hours(emg_c),
		.tot_units(tot_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			mode_q   <= mode_c;
			status_q <= status_c;
			fail_q   <= fail_c;
			charge_q <= charge_c;
			dur_q    <= dur_c;
			emg_q    <= emg_c;
			tot_q    <= tot_c;
		end
	end

	assign rsp.valid                = out_v_q;
	assign rsp.mode_bits            = mode_q;
	assign rsp.status_bits          = status_q;
	assign rsp.failure_bits         = fail_q;
	assign rsp.battery_charge       = charge_q;
	assign rsp.duration_result      = dur_q;
	assign rsp.lamp_emergency_hours = emg_q;
	assign rsp.lamp_total_units     = tot_q;

endmodule

[rtl/elmc_checker.sv]
`include "emergency_lighting_mode_controller_defines.svh"

module elmc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [5:0] mode_bits,
	input logic [5:0] status_bits,
	input logic [7:0] failure_bits
);

	// a stalled result stays put
	`ELMC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(mode_bits) && $stable(status_bits))
	// exactly one mode is reported
	`ELMC_ASSERT_NOW(a_mode_onehot, clk, arst_n, out_valid, $onehot(mode_bits))
	// inhibit only shows in normal (inhibit) or rest
	`ELMC_ASSERT_NOW(a_inhibit_mode, clk, arst_n, out_valid && status_bits[0], mode_bits[1] || mode_bits[0])
	// only the battery failure bit can be set
	`ELMC_ASSERT_NOW(a_fail_bits, clk, arst_n, out_valid, (failure_bits & 8'hFB) == 8'h00)

endmodule

bind emergency_lighting_mode_controller elmc_checker u_elmc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(rsp.valid),
	.out_ready(rsp.ready),
	.mode_bits(rsp.mode_bits),
	.status_bits(rsp.status_bits),
	.failure_bits(rsp.failure_bits)
);

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
	import elmc_pkg::*;

	localparam int unsigned DUR_UNIT = 120;
	localparam int unsigned CHARGE_FULL_SCALE = 254;

	typedef enum logic [2:0] {
		MD_NORMAL,
		MD_INHIBIT,
		MD_REST,
		MD_EMERG,
		MD_EXT,
		MD_FUNC,
		MD_DUR
	} op_mode_t;

	typedef struct packed {
		logic [2:0] req_type;
		logic       mains_on;
		logic       shorten_test;
		logic [6:0] battery_percent;
	} request_t;

	typedef struct packed {
		logic [5:0] mode_bits;
		logic [5:0] status_bits;
		logic [7:0] failure_bits;
		logic [7:0] battery_charge;
		logic [7:0] duration_result;
		logic [7:0] lamp_emergency_hours;
		logic [7:0] lamp_total_units;
	} report_t;

	// Mirror of the gear state; produces the report each request should yield and
	// keeps those reports in order until the block delivers them.
	class mode_tracker;
		logic [7:0]  prolong_time;
		op_mode_t    mode;
		logic        inhibit_flag;
		logic        func_done;
		logic        dur_done;
		logic        charged;
		logic        func_pend;
		logic        dur_pend;
		logic        battery_fail;
		logic [9:0]  inhibit_count;
		logic [12:0] prolong_count;
		logic [2:0]  func_count;
		logic [11:0] dur_count;
		logic [31:0] lamp_emg_s;
		logic [31:0] lamp_tot_s;
		report_t     reports_due[$];
		int unsigned errors;

		function new();
			prolong_time  = '0;
			mode          = MD_NORMAL;
			inhibit_flag  = 1'b0;
			func_done     = 1'b0;
			dur_done      = 1'b0;
			charged       = 1'b0;
			func_pend     = 1'b0;
			dur_pend      = 1'b0;
			battery_fail  = 1'b0;
			inhibit_count = '0;
			prolong_count = '0;
			func_count    = '0;
			dur_count     = '0;
			lamp_emg_s    = '0;
			lamp_tot_s    = '0;
			errors        = 0;
		endfunction

		// inhibit flag survives a move into rest, cleared by any other mode
		function void switch_mode(op_mode_t m);
			mode = m;
			if (m == MD_INHIBIT) begin
				inhibit_flag = 1'b1;
			end else if (m != MD_REST) begin
				inhibit_flag = 1'b0;
			end
			if (m == MD_FUNC) begin
				func_done  = 1'b0;
				func_pend  = 1'b0;
				func_count = '0;
			end else if (m == MD_DUR) begin
				dur_done  = 1'b0;
				dur_pend  = 1'b0;
				dur_count = '0;
			end
		endfunction

		// one second of time; all counters saturate
		function void advance_second(logic mains, logic shorten, logic [6:0] pct);
			logic full;
			logic empty;
			full  = (pct == FULL_PERCENT);
			empty = (pct == 7'd0);
			case (mode)
				MD_FUNC: begin
					if (!mains) begin
						switch_mode(MD_EMERG);
					end else begin
						if (func_count != 3'h7) func_count = func_count + 3'd1;
						if (func_count == FUNC_TEST_TICKS_DEF) begin
							func_done = 1'b1;
							switch_mode(MD_NORMAL);
						end
					end
				end
				MD_DUR: begin
					if (!mains) begin
						switch_mode(MD_EMERG);
					end else begin
						if (dur_count != 12'hFFF) dur_count = dur_count + 12'd1;
						if (dur_count == DUR_TEST_TICKS_DEF) begin
							dur_done = 1'b1;
							switch_mode(MD_NORMAL);
						end
						if (shorten) begin
							dur_count = DUR_TEST_TICKS_DEF;
							dur_done  = 1'b1;
							switch_mode(MD_NORMAL);
						end
						if (empty) begin
							dur_done     = 1'b1;
							battery_fail = 1'b1;
							switch_mode(MD_NORMAL);
						end
					end
				end
				MD_NORMAL: begin
					if (!mains) begin
						switch_mode(MD_EMERG);
					end else if (func_pend && full) begin
						switch_mode(MD_FUNC);
					end else if (dur_pend && full) begin
						switch_mode(MD_DUR);
					end
				end
				MD_INHIBIT: begin
					if (!mains) begin
						switch_mode(MD_REST);
					end else if (inhibit_count >= INHIBIT_TICKS_DEF) begin
						switch_mode(MD_NORMAL);
					end else if (inhibit_count != 10'h3FF) begin
						inhibit_count = inhibit_count + 10'd1;
					end
				end
				MD_REST: begin
					if (mains) switch_mode(MD_NORMAL);
				end
				MD_EMERG: begin
					if (mains && prolong_time != 8'd0) begin
						switch_mode(MD_EXT);
						prolong_count = '0;
					end else if (mains) begin
						switch_mode(MD_NORMAL);
						prolong_count = '0;
					end else if (empty) begin
						switch_mode(MD_REST);
					end else if (lamp_emg_s != '1) begin
						lamp_emg_s = lamp_emg_s + 32'd1;
					end
				end
				MD_EXT: begin
					if (!mains) begin
						switch_mode(MD_EMERG);
					end else if (32'(prolong_count) >= prolong_time * PROLONG_STEP) begin
						switch_mode(MD_NORMAL);
					end else if (empty) begin
						switch_mode(MD_NORMAL);
					end else if (prolong_count != 13'h1FFF) begin
						prolong_count = prolong_count + 13'd1;
					end
				end
				default: ;
			endcase
			charged = full;
			if (lamp_tot_s != '1) lamp_tot_s = lamp_tot_s + 32'd1;
		endfunction

		function logic [7:0] coarse(longint unsigned v, longint unsigned unit_s);
			longint unsigned q;
			q = v / unit_s;
			return (q > 255) ? 8'd255 : 8'(q);
		endfunction

		function void note_request(request_t r);
			logic [6:0] pct;
			report_t    want;
			pct = (r.battery_percent > FULL_PERCENT) ? FULL_PERCENT : r.battery_percent;
			case (r.req_type)
				REQ_TICK: advance_second(r.mains_on, r.shorten_test, pct);
				REQ_REST: begin
					if (mode == MD_EMERG) switch_mode(MD_REST);
				end
				REQ_INHIBIT: begin
					if (mode == MD_NORMAL) begin
						switch_mode(MD_INHIBIT);
						inhibit_count = '0;
					end else if (mode == MD_INHIBIT) begin
						inhibit_count = '0;
					end
				end
				REQ_RELIGHT: begin
					if (mode == MD_REST) switch_mode(MD_EMERG);
					else if (mode == MD_INHIBIT) switch_mode(MD_NORMAL);
				end
				REQ_FUNC_TEST: begin
					if (mode == MD_NORMAL) switch_mode(MD_FUNC);
					else func_pend = 1'b1;
				end
				REQ_DUR_TEST: begin
					if (mode == MD_NORMAL && pct == FULL_PERCENT) switch_mode(MD_DUR);
					else dur_pend = 1'b1;
				end
				REQ_STOP_TEST: begin
					if (mode == MD_DUR || mode == MD_FUNC) switch_mode(MD_NORMAL);
					func_pend = 1'b0;
					dur_pend  = 1'b0;
				end
				default: begin
					lamp_emg_s = '0;
					lamp_tot_s = '0;
				end
			endcase

			case (mode)
				MD_REST:               want.mode_bits = 6'b000001;
				MD_NORMAL, MD_INHIBIT: want.mode_bits = 6'b000010;
				MD_EMERG:              want.mode_bits = 6'b000100;
				MD_EXT:                want.mode_bits = 6'b001000;
				MD_FUNC:               want.mode_bits = 6'b010000;
				default:               want.mode_bits = 6'b100000;
			endcase
			want.status_bits = {dur_pend, func_pend, charged, dur_done, func_done, inhibit_flag};
			want.failure_bits = {5'd0, battery_fail, 2'd0};
			want.battery_charge = 8'((32'(pct) * CHARGE_FULL_SCALE) / 100);
			want.duration_result = coarse(64'(dur_count), 64'(DUR_UNIT));
			want.lamp_emergency_hours = coarse(64'(lamp_emg_s), 64'(EMG_STEP));
			want.lamp_total_units = coarse(64'(lamp_tot_s), 64'(TOT_STEP));
			reports_due.push_back(want);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_report(report_t got);
			report_t want;
			if (reports_due.size() == 0) begin
				$error("report with no request outstanding: mode_bits %0d", got.mode_bits);
				errors++;
				return;
			end
			want = reports_due.pop_front();
			compare_field("mode_bits", 8'(want.mode_bits), 8'(got.mode_bits));
			compare_field("status_bits", 8'(want.status_bits), 8'(got.status_bits));
			compare_field("failure_bits", want.failure_bits, got.failure_bits);
			compare_field("battery_charge", want.battery_charge, got.battery_charge);
			compare_field("duration_result", want.duration_result, got.duration_result);
			compare_field("lamp_emergency_hours", want.lamp_emergency_hours,
				got.lamp_emergency_hours);
			compare_field("lamp_total_units", want.lamp_total_units, got.lamp_total_units);
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;

	elmc_req_if req_ch();
	elmc_rsp_if rsp_ch();

	mode_tracker tracker = new();
	bit          idle_on = 1'b1;
	bit          soak_done = 1'b0;
	int unsigned requests_sent = 0;

	emergency_lighting_mode_controller u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: random back-pressure, changed at the falling edge.
	always @(negedge clk) begin
		rsp_ch.ready <= !(idle_on && $urandom_range(0, 99) < 9);
	end

	// Results are taken at the rising edge, where valid and ready are stable.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			tracker.check_report(report_t'{
				mode_bits:            rsp_ch.mode_bits,
				status_bits:          rsp_ch.status_bits,
				failure_bits:         rsp_ch.failure_bits,
				battery_charge:       rsp_ch.battery_charge,
				duration_result:      rsp_ch.duration_result,
				lamp_emergency_hours: rsp_ch.lamp_emergency_hours,
				lamp_total_units:     rsp_ch.lamp_total_units});
		end
	end

	function automatic request_t make_request(logic [2:0] kind, logic mains, logic shorten,
		logic [6:0] pct);
		return request_t'{req_type: kind, mains_on: mains, shorten_test: shorten,
			battery_percent: pct};
	endfunction

	// mostly full charge, with empty, partial and out-of-range levels mixed in
	function automatic logic [6:0] pick_pct();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r <= 5) return FULL_PERCENT;
		if (r == 6) return 7'd0;
		if (r == 7) return 7'($urandom_range(101, 127));
		return 7'($urandom_range(1, 99));
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance with
	// valid still high, so the next call or drain decides what valid does next.
	task automatic send_request(request_t r);
		while (idle_on && $urandom_range(0, 99) < 9) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid           <= 1'b1;
		req_ch.req_type        <= r.req_type;
		req_ch.mains_on        <= r.mains_on;
		req_ch.shorten_test    <= r.shorten_test;
		req_ch.battery_percent <= r.battery_percent;
		do @(posedge clk); while (!req_ch.ready);
		tracker.note_request(r);
		requests_sent++;
		@(negedge clk);
	endtask

	// Hold off the sender until every outstanding report has come back.
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(negedge clk);
		while (tracker.reports_due.size() != 0) @(negedge clk);
	endtask

	task automatic write_prolong(logic [7:0] v);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		tracker.prolong_time = v;
	endtask

	// One burst of stimulus built around a typical use of the gear.
	task automatic run_scenario();
		int unsigned kind;
		int unsigned len;
		logic [2:0]  cmd;
		kind = $urandom_range(0, 9);
		if ($urandom_range(0, 19) == 0) drain();
		case (kind)
			0, 1: begin
				// pure noise over the whole field ranges
				len = $urandom_range(4, 20);
				repeat (len) send_request(make_request(3'($urandom_range(0, 7)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					7'($urandom_range(0, 127))));
			end
			2, 3: begin
				// self test run, mostly on mains with full battery
				send_request(make_request((kind == 2) ? REQ_FUNC_TEST : REQ_DUR_TEST,
					1'b1, 1'b0, pick_pct()));
				len = $urandom_range(5, 150);
				repeat (len) begin
					cmd = ($urandom_range(0, 79) == 0) ? REQ_STOP_TEST : REQ_TICK;
					send_request(make_request(cmd, $urandom_range(0, 99) != 0,
						$urandom_range(0, 59) == 0,
						($urandom_range(0, 199) == 0) ? 7'd0 : FULL_PERCENT));
				end
			end
			4, 5: begin
				// mains outage, then mains back (extended emergency)
				len = $urandom_range(3, 80);
				repeat (len) begin
					case ($urandom_range(0, 49))
						0:       cmd = REQ_REST;
						1:       cmd = REQ_RELIGHT;
						default: cmd = REQ_TICK;
					endcase
					send_request(make_request(cmd, 1'b0, 1'($urandom_range(0, 1)),
						($urandom_range(0, 39) == 0) ? 7'd0 : 7'($urandom_range(1, 127))));
				end
				len = $urandom_range(3, 80);
				repeat (len) send_request(make_request(REQ_TICK,
					$urandom_range(0, 29) != 0, 1'b0,
					($urandom_range(0, 49) == 0) ? 7'd0 : pick_pct()));
			end
			6: begin
				// back to normal mode, then inhibit; the first one runs to expiry
				send_request(make_request(REQ_STOP_TEST, 1'b1, 1'b0, 7'd50));
				repeat (3) send_request(make_request(REQ_TICK, 1'b1, 1'b0, 7'd0));
				send_request(make_request(REQ_INHIBIT, 1'b1, 1'b0, pick_pct()));
				len = soak_done ? $urandom_range(5, 60) : 930;
				repeat (len) begin
					cmd = REQ_TICK;
					if (soak_done && $urandom_range(0, 39) == 0) begin
						cmd = $urandom_range(0, 1) ? REQ_RELIGHT : REQ_INHIBIT;
					end
					send_request(make_request(cmd,
						!soak_done ? 1'b1 : ($urandom_range(0, 19) != 0),
						1'($urandom_range(0, 1)), pick_pct()));
				end
				soak_done = 1'b1;
			end
			7: begin
				// tests requested while not ready, started later by a full battery
				len = $urandom_range(1, 3);
				repeat (len) send_request(make_request(
					$urandom_range(0, 1) ? REQ_FUNC_TEST : REQ_DUR_TEST,
					1'($urandom_range(0, 1)), 1'b0, 7'($urandom_range(0, 99))));
				len = $urandom_range(5, 40);
				repeat (len) send_request(make_request(REQ_TICK, 1'b1,
					$urandom_range(0, 29) == 0, FULL_PERCENT));
			end
			default: begin
				// ticks with commands sprinkled in
				len = $urandom_range(5, 30);
				repeat (len) begin
					cmd = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(1, 7)) : REQ_TICK;
					send_request(make_request(cmd, $urandom_range(0, 5) != 0,
						$urandom_range(0, 19) == 0, pick_pct()));
				end
			end
		endcase
	endtask

	initial begin
		logic [7:0]  phase_prolong [4];
		int unsigned target;

		arst_n                 = 1'b0;
		cfg_wr_en              = 1'b0;
		cfg_wr_data            = '0;
		req_ch.valid           = 1'b0;
		req_ch.req_type        = REQ_TICK;
		req_ch.mains_on        = 1'b1;
		req_ch.shorten_test    = 1'b0;
		req_ch.battery_percent = '0;
		rsp_ch.ready           = 1'b0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: a short extended emergency, battery extremes, every command.
		write_prolong(8'd2);
		send_request(make_request(REQ_TICK, 1'b1, 1'b0, 7'd0));
		send_request(make_request(REQ_TICK, 1'b1, 1'b1, 7'd127)); // clamps to 100
		send_request(make_request(REQ_TICK, 1'b1, 1'b0, FULL_PERCENT));
		send_request(make_request(REQ_FUNC_TEST, 1'b1, 1'b0, FULL_PERCENT));
		repeat (5) send_request(make_request(REQ_TICK, 1'b1, 1'b0, FULL_PERCENT));
		send_request(make_request(REQ_DUR_TEST, 1'b1, 1'b0, FULL_PERCENT));
		send_request(make_request(REQ_TICK, 1'b1, 1'b1, FULL_PERCENT)); // shortened
		send_request(make_request(REQ_DUR_TEST, 1'b1, 1'b0, 7'd50)); // only pending
		send_request(make_request(REQ_TICK, 1'b1, 1'b0, FULL_PERCENT)); // pending starts
		send_request(make_request(REQ_STOP_TEST, 1'b1, 1'b0, FULL_PERCENT));
		send_request(make_request(REQ_INHIBIT, 1'b1, 1'b0, FULL_PERCENT));
		send_request(make_request(REQ_FUNC_TEST, 1'b1, 1'b0, FULL_PERCENT)); // pending only
		// mains loss out of inhibit: rest, inhibit status kept
		send_request(make_request(REQ_TICK, 1'b0, 1'b0, 7'd80));
		send_request(make_request(REQ_REST, 1'b0, 1'b0, 7'd80)); // no effect in rest
		send_request(make_request(REQ_RELIGHT, 1'b0, 1'b0, 7'd80));
		send_request(make_request(REQ_TICK, 1'b0, 1'b0, 7'd80));
		send_request(make_request(REQ_REST, 1'b0, 1'b0, 7'd80));
		send_request(make_request(REQ_RELIGHT, 1'b0, 1'b0, 7'd80));
		send_request(make_request(REQ_TICK, 1'b1, 1'b0, 7'd80)); // into extended
		send_request(make_request(REQ_TICK, 1'b1, 1'b0, 7'd80));
		// prolong time dropped while extended emergency runs
		write_prolong(8'd0);
		send_request(make_request(REQ_TICK, 1'b1, 1'b0, 7'd80));
		send_request(make_request(REQ_LAMP_CLR, 1'b1, 1'b0, 7'd80));
		send_request(make_request(REQ_INHIBIT, 1'b1, 1'b0, 7'd80));
		send_request(make_request(REQ_RELIGHT, 1'b1, 1'b0, 7'd80));

		// Random part in four settings; the second one runs with no idle cycles.
		// The phases share one overall budget, so the long inhibit soak shortens
		// the ones after it; each phase still gets at least 100 requests.
		phase_prolong[0] = 8'd255;
		phase_prolong[1] = 8'd1;
		phase_prolong[2] = 8'($urandom_range(2, 20));
		phase_prolong[3] = 8'd0;
		for (int unsigned p = 0; p < 4; p++) begin
			write_prolong(phase_prolong[p]);
			idle_on = (p != 1);
			target = (p + 1) * 375;
			if (target < requests_sent + 100) target = requests_sent + 100;
			while (requests_sent < target) run_scenario();
		end

		drain();
		repeat (5) @(negedge clk);
		if (tracker.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
